// ===== design/bpc_pkg.sv =====
`default_nettype none

package bpc_pkg;

    // Field widths
    localparam int unsigned WIN_W     = 20;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // Window register reset values, in ticks
    localparam logic [WIN_W-1:0] HOLD_WINDOW_RST = 20'd500000;
    localparam logic [WIN_W-1:0] GAP_WINDOW_RST  = 20'd300000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_WINDOW  = 1'd1;

    // Press status codes
    localparam logic [STATUS_W-1:0] ST_OFF    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ON     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SINGLE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LONG   = 3'd4;

    // Pin level meaning pressed (active low)
    localparam logic LEVEL_PRESSED = 1'b0;

endpackage

`default_nettype wire

// ===== design/button_press_classifier.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_button_level
// result    out        o_out_valid / i_out_ready  o_press_status
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One sample per cycle while the output is not stalled: each accepted sample
// updates the phase and window counter and loads its status into the output
// register in the same cycle; the result appears in the following cycle.
// A sample is taken whenever the output register is empty or being drained.
// Synchronous active-low reset: idle phase, status off, default windows, no output.
`default_nettype none

module button_press_classifier (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_button_level,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [bpc_pkg::STATUS_W-1:0]       o_press_status,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bpc_pkg::WIN_W-1:0]     i_cfg_data
);
    import bpc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HOLD,
        PH_GAP,
        PH_LOCK
    } t_phase;

    t_phase              r_phase,        n_phase;
    logic [WIN_W-1:0]    r_window_count, n_window_count;
    logic [STATUS_W-1:0] r_held_status,  n_held_status;
    logic [WIN_W-1:0]    r_hold_window;
    logic [WIN_W-1:0]    r_gap_window;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_press_status;

    logic                in_fire;
    logic                pressed;
    logic [WIN_W-1:0]    count_inc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign pressed     = (i_button_level == LEVEL_PRESSED);
    assign count_inc   = r_window_count + 1'b1;

    // Next phase, window count and status for the current sample
    always_comb begin
        n_phase        = r_phase;
        n_window_count = r_window_count;
        n_held_status  = r_held_status;
        case (r_phase)
            PH_IDLE: begin
                if (pressed) begin
                    n_phase        = PH_HOLD;
                    n_window_count = '0;
                end
            end
            PH_HOLD: begin
                if (!pressed) begin
                    n_phase        = PH_GAP;
                    n_window_count = '0;
                end else begin
                    n_window_count = count_inc;
                    if (count_inc >= r_hold_window) begin
                        n_held_status = ST_LONG;
                        n_phase       = PH_LOCK;
                    end
                end
            end
            PH_GAP: begin
                if (pressed) begin
                    n_held_status = ST_DOUBLE;
                    n_phase       = PH_LOCK;
                end else begin
                    n_window_count = count_inc;
                    if (count_inc >= r_gap_window) begin
                        n_held_status = ST_SINGLE;
                        n_phase       = PH_LOCK;
                    end
                end
            end
            PH_LOCK: begin
                if (!pressed) begin
                    n_held_status = ST_OFF;
                    n_phase       = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // State, window registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_window_count <= '0;
            r_held_status  <= ST_OFF;
            r_hold_window  <= HOLD_WINDOW_RST;
            r_gap_window   <= GAP_WINDOW_RST;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_HOLD_WINDOW: r_hold_window <= i_cfg_data;
                    CFG_GAP_WINDOW:  r_gap_window  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_phase        <= n_phase;
                r_window_count <= n_window_count;
                r_held_status  <= n_held_status;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each transaction
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_press_status <= n_held_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_press_status = r_press_status;

endmodule

`default_nettype wire

// ===== design/bpc_checker.sv =====
`default_nettype none

module bpc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          i_button_level,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [bpc_pkg::STATUS_W-1:0]  o_press_status
);
    import bpc_pkg::*;

    // Only off, single, double and long are ever reported
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_press_status == ST_OFF || o_press_status == ST_SINGLE ||
                         o_press_status == ST_DOUBLE || o_press_status == ST_LONG))
        else $error("bpc: invalid press status code");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_press_status))
        else $error("bpc: stalled result changed");

    // Empty output stage never blocks input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("bpc: input stalled with empty output");

    // A released sample can only give off or single press
    a_release_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_button_level != LEVEL_PRESSED) |=>
            o_out_valid && (o_press_status == ST_OFF || o_press_status == ST_SINGLE))
        else $error("bpc: release gave double or long press");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_button_level (i_button_level),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_press_status (o_press_status)
);

`default_nettype wire

// ===== tb/sv/button_press_classifier_test.sv =====
`timescale 1ns / 1ps

module button_press_classifier_test;
    import bpc_pkg::*;

    // Local view of the classifier phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HOLD,
        PH_GAP,
        PH_LOCK
    } t_press_phase;

    localparam int unsigned RANDOM_SAMPLES = 1750;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam logic [WIN_W-1:0] WIN_MAX   = {WIN_W{1'b1}};

    // DUT ports
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic                 i_button_level = 1'b1;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic [STATUS_W-1:0]  o_press_status;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_HOLD_WINDOW;
    logic [WIN_W-1:0]     i_cfg_data     = '0;

    // Predictor state and its copy of the window registers
    t_press_phase         press_phase  = PH_IDLE;
    logic [WIN_W-1:0]     tick_count   = '0;
    logic [STATUS_W-1:0]  cur_status   = ST_OFF;
    logic [WIN_W-1:0]     hold_len     = HOLD_WINDOW_RST;
    logic [WIN_W-1:0]     gap_len      = GAP_WINDOW_RST;

    // Pending button samples and statuses still to come
    logic                 level_pending[$];
    logic [STATUS_W-1:0]  status_expected[$];

    // Traffic shaping
    bit                   idle_on      = 1'b0;
    int unsigned          stall_req    = 0;
    int unsigned          stall_seen   = 0;
    int unsigned          send_gap     = 0;
    int unsigned          recv_gap     = 0;
    int unsigned          hold_left    = 0;

    // Bookkeeping
    int unsigned          error_count   = 0;
    int unsigned          samples_sent  = 0;
    int unsigned          results_seen  = 0;
    int unsigned          samples_plan  = 0;
    int unsigned          phases_run    = 0;
    int unsigned          singles_seen  = 0;
    int unsigned          doubles_seen  = 0;
    int unsigned          longs_seen    = 0;

    button_press_classifier i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_button_level (i_button_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_press_status (o_press_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the predictor by one sample and return the new status
    function automatic logic [STATUS_W-1:0] classify_sample(input logic level);
        logic pressed;
        pressed = (level == LEVEL_PRESSED);
        case (press_phase)
            PH_IDLE: begin
                if (pressed) begin
                    press_phase = PH_HOLD;
                    tick_count  = '0;
                end
            end
            PH_HOLD: begin
                if (!pressed) begin
                    press_phase = PH_GAP;
                    tick_count  = '0;
                end else begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count >= hold_len) begin
                        cur_status  = ST_LONG;
                        press_phase = PH_LOCK;
                        longs_seen++;
                    end
                end
            end
            PH_GAP: begin
                if (pressed) begin
                    cur_status  = ST_DOUBLE;
                    press_phase = PH_LOCK;
                    doubles_seen++;
                end else begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count >= gap_len) begin
                        cur_status  = ST_SINGLE;
                        press_phase = PH_LOCK;
                        singles_seen++;
                    end
                end
            end
            default: begin
                if (!pressed) begin
                    cur_status  = ST_OFF;
                    press_phase = PH_IDLE;
                end
            end
        endcase
        return cur_status;
    endfunction

    // Idle gap length: mostly none, sometimes short, rarely long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Window setting: mostly small, with zero, max and large values mixed in
    function automatic logic [WIN_W-1:0] pick_window();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return WIN_MAX;
        if (r < 4) return WIN_W'($urandom_range(20, 60));
        if (r == 4) return WIN_W'($urandom_range(61, 32'(WIN_MAX) - 1));
        return WIN_W'($urandom_range(1, 12));
    endfunction

    // Duration in ticks, clustered around the window boundary; short for windows above 64
    function automatic int unsigned pick_len(input logic [WIN_W-1:0] win);
        int unsigned w;
        if (32'(win) > 64) return $urandom_range(1, 6);
        w = (win == '0) ? 1 : 32'(win);
        case ($urandom_range(0, 5))
            0: return w;
            1: return w + 1;
            2: return w + 2;
            3: return $urandom_range(1, 3);
            default: return $urandom_range(1, w + 3);
        endcase
    endfunction

    task automatic push_level(input logic level, input int unsigned n);
        repeat (n) begin
            level_pending.push_back(level);
            samples_plan++;
        end
    endtask

    // Register write; called right after a rising edge
    task automatic write_window(input logic [CFG_IDX_W-1:0] idx,
                                input logic [WIN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_HOLD_WINDOW) hold_len = value;
        else gap_len = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every sample is sent and every status has come back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (level_pending.size() != 0 || i_in_valid || status_expected.size() != 0);
    endtask

    // One random gesture: single, double, long, or raw noise
    task automatic push_gesture();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        push_level(1'b1, $urandom_range(0, 2));
        case (kind)
            0, 1, 2: begin
                push_level(LEVEL_PRESSED, pick_len(hold_len));
                push_level(~LEVEL_PRESSED, pick_len(gap_len) + 1);
            end
            3, 4, 5: begin
                push_level(LEVEL_PRESSED, pick_len(hold_len));
                push_level(~LEVEL_PRESSED, pick_len(gap_len));
                push_level(LEVEL_PRESSED, $urandom_range(1, 4));
                push_level(~LEVEL_PRESSED, $urandom_range(1, 3));
            end
            6, 7: begin
                push_level(LEVEL_PRESSED, pick_len(hold_len));
                push_level(~LEVEL_PRESSED, $urandom_range(1, 3));
            end
            default: begin
                repeat ($urandom_range(1, 10)) push_level(1'($urandom_range(0, 1)), 1);
            end
        endcase
    endtask

    // Driver: offers queued samples, predicts on every accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid     <= 1'b0;
            i_button_level <= 1'b1;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                status_expected.push_back(classify_sample(i_button_level));
                samples_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (level_pending.size() > 0) begin
                    i_in_valid     <= 1'b1;
                    i_button_level <= level_pending.pop_front();
                    send_gap = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction, drives ready with gaps and stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (status_expected.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected status %0d, nothing expected",
                             $time, o_press_status);
                end else if (o_press_status !== status_expected[0]) begin
                    error_count++;
                    $display("%0t: press_status mismatch: expected %0d, actual %0d",
                             $time, status_expected[0], o_press_status);
                    void'(status_expected.pop_front());
                end else begin
                    void'(status_expected.pop_front());
                end
            end
            if (stall_req != stall_seen) begin
                stall_seen = stall_req;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int unsigned phase_goal;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset windows: idle release, then a quick double press and release
        push_level(1'b1, 1);
        push_level(LEVEL_PRESSED, 2);
        push_level(~LEVEL_PRESSED, 1);
        push_level(LEVEL_PRESSED, 1);
        push_level(~LEVEL_PRESSED, 2);
        wait_drained();

        // Minimum windows: long press with held lock, then single press
        write_window(CFG_HOLD_WINDOW, 20'd1);
        write_window(CFG_GAP_WINDOW, 20'd1);
        push_level(LEVEL_PRESSED, 3);
        push_level(~LEVEL_PRESSED, 1);
        push_level(LEVEL_PRESSED, 1);
        push_level(~LEVEL_PRESSED, 3);
        wait_drained();

        // Zero windows behave like one
        write_window(CFG_HOLD_WINDOW, '0);
        write_window(CFG_GAP_WINDOW, '0);
        push_level(LEVEL_PRESSED, 2);
        push_level(~LEVEL_PRESSED, 1);
        push_level(LEVEL_PRESSED, 1);
        push_level(~LEVEL_PRESSED, 3);
        wait_drained();

        // Maximum windows: double press, then leave a hold window open
        write_window(CFG_HOLD_WINDOW, WIN_MAX);
        write_window(CFG_GAP_WINDOW, WIN_MAX);
        push_level(LEVEL_PRESSED, 1);
        push_level(~LEVEL_PRESSED, 1);
        push_level(LEVEL_PRESSED, 1);
        push_level(~LEVEL_PRESSED, 1);
        push_level(LEVEL_PRESSED, 2);
        wait_drained();

        // Random phases; the first shrinks the open hold window
        samples_plan = 0;
        while (samples_plan < RANDOM_SAMPLES) begin
            if (phases_run == 0) begin
                write_window(CFG_HOLD_WINDOW, 20'd1);
                write_window(CFG_GAP_WINDOW, pick_window());
            end else begin
                if ($urandom_range(0, 9) < 7) write_window(CFG_HOLD_WINDOW, pick_window());
                if ($urandom_range(0, 9) < 7) write_window(CFG_GAP_WINDOW, pick_window());
            end
            idle_on = ($urandom_range(0, 3) != 0);
            if (phases_run == 3) begin
                idle_on = 1'b0;
                stall_req++;
            end
            phase_goal = samples_plan + $urandom_range(40, 150);
            while (samples_plan < phase_goal) push_gesture();
            phases_run++;
            wait_drained();
        end

        repeat (5) @(posedge i_clk);
        if (status_expected.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected statuses never arrived",
                     $time, status_expected.size());
        end

        $display("Run: %0d samples over %0d random phases, %0d statuses checked",
                 samples_sent, phases_run, results_seen);
        $display("Decisions: %0d single, %0d double, %0d long press",
                 singles_seen, doubles_seen, longs_seen);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("%0t: run timed out", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/bpc_pkg.sv
design/button_press_classifier.sv
design/bpc_checker.sv
tb/sv/button_press_classifier_test.sv
